[hdl/zpr_pkg.sv]
// ----------------------------------------------------------------------------
// zpr_pkg: shared types and constants of the Z-order particle router
// Field widths, register indexes, transaction structs and the Morton
// interleave used by both the front end and the configuration unit.
// ----------------------------------------------------------------------------
`default_nettype none

package zpr_pkg;

   localparam int AXIS_BITS    = 10;
   localparam int DEST_BITS    = 16;
   localparam int FIELD_BITS   = 10;
   localparam int COORD_BITS   = 32;
   localparam int TAG_BITS     = 32;
   localparam int GRID_BITS    = 3 * FIELD_BITS;
   localparam int MORTON_BITS  = 3 * AXIS_BITS;
   localparam int DEN_BITS     = MORTON_BITS + 1;
   localparam int SUM_BITS     = ((MORTON_BITS > DEST_BITS) ? MORTON_BITS : DEST_BITS) + 1;
   localparam int STEP_BITS    = (MORTON_BITS > 1) ? $clog2(MORTON_BITS) : 1;
   localparam int CSR_IDX_BITS = 3;
   localparam int QUEUE_DEPTH  = 8;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int OCC_BITS     = QPTR_BITS + 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ORIGIN_Z   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_X    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_Y    = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_Z    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_LAST  = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEST_COUNT = 3'd7;

   localparam logic [COORD_BITS-1:0] SCALE_RESET = 32'd65536;
   localparam logic [GRID_BITS-1:0]  GRID_RESET  = 30'd7347207;
   localparam logic [DEST_BITS-1:0]  DEST_RESET  = 16'd1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic [TAG_BITS-1:0]          particle_index;
   } req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]    particle_tag;
      logic [DEST_BITS-1:0]   destination;
      logic [MORTON_BITS-1:0] morton_code;
   } rsp_type;

   // Live configuration plus the values derived from it
   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] origin_z;
      logic [COORD_BITS-1:0]        scale_x;
      logic [COORD_BITS-1:0]        scale_y;
      logic [COORD_BITS-1:0]        scale_z;
      logic [AXIS_BITS-1:0]         last_x;
      logic [AXIS_BITS-1:0]         last_y;
      logic [AXIS_BITS-1:0]         last_z;
      logic [DEST_BITS-1:0]         n;
      logic [DEST_BITS-1:0]         n_last;
      logic [MORTON_BITS-1:0]       per;
      logic [DEN_BITS-1:0]          per_inc;
      logic [DEST_BITS-1:0]         off;
      logic [MORTON_BITS-1:0]       lo;
   } cfg_type;

   // Classified item waiting for the divider
   typedef struct packed {
      logic [TAG_BITS-1:0]    tag;
      logic [MORTON_BITS-1:0] morton;
      logic [MORTON_BITS-1:0] num;
      logic [DEN_BITS-1:0]    den;
      logic [DEST_BITS-1:0]   base;
      logic                   last_dest;
   } entry_type;

   function automatic logic [MORTON_BITS-1:0] interleave(
      input logic [AXIS_BITS-1:0] x,
      input logic [AXIS_BITS-1:0] y,
      input logic [AXIS_BITS-1:0] z
   );
      logic [MORTON_BITS-1:0] m;
      m = '0;
      for (int i = 0; i < AXIS_BITS; i++) begin
         m[3*i]     = x[i];
         m[3*i + 1] = y[i];
         m[3*i + 2] = z[i];
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[hdl/zpr_cfg.sv]
// ----------------------------------------------------------------------------
// zpr_cfg: configuration registers and range derivation
// Holds the registers and, after reset or any write, divides the last Morton
// code by the destination count one bit a cycle, then forms the wide-range end.
// ----------------------------------------------------------------------------
`default_nettype none

module zpr_cfg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [zpr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [zpr_pkg::COORD_BITS-1:0]      csr_data,
   output zpr_pkg::cfg_type                    cfg
);

   typedef enum logic [1:0] {ST_LOAD, ST_DIV, ST_MUL, ST_IDLE} state_type;

   state_type                             state_ff;
   logic signed [zpr_pkg::COORD_BITS-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [zpr_pkg::COORD_BITS-1:0]        scale_x_ff, scale_y_ff, scale_z_ff;
   logic [zpr_pkg::GRID_BITS-1:0]         grid_last_ff;
   logic [zpr_pkg::DEST_BITS-1:0]         dest_count_ff;
   logic [zpr_pkg::MORTON_BITS-1:0]       dvd_ff, quot_ff, lo_ff;
   logic [zpr_pkg::DEST_BITS-1:0]         rem_ff;
   logic [zpr_pkg::DEN_BITS-1:0]          per_inc_ff;
   logic [zpr_pkg::STEP_BITS-1:0]         step_ff;

   logic [zpr_pkg::AXIS_BITS-1:0]         last_x, last_y, last_z;
   logic [zpr_pkg::DEST_BITS-1:0]         n_eff;
   logic [zpr_pkg::MORTON_BITS-1:0]       mx;
   logic [zpr_pkg::DEST_BITS:0]           trial, trial_sub;
   logic                                  ge;
   logic [zpr_pkg::DEST_BITS-1:0]         rem_in;
   logic [zpr_pkg::DEN_BITS-1:0]          per_inc_in;
   logic [zpr_pkg::DEST_BITS+zpr_pkg::DEN_BITS-1:0] lo_prod;

   assign last_x = grid_last_ff[0*zpr_pkg::FIELD_BITS +: zpr_pkg::AXIS_BITS];
   assign last_y = grid_last_ff[1*zpr_pkg::FIELD_BITS +: zpr_pkg::AXIS_BITS];
   assign last_z = grid_last_ff[2*zpr_pkg::FIELD_BITS +: zpr_pkg::AXIS_BITS];
   assign n_eff  = (dest_count_ff == '0) ? zpr_pkg::DEST_BITS'(1) : dest_count_ff;
   assign mx     = zpr_pkg::interleave(last_x, last_y, last_z);

   // One restoring-division step of the last code by the destination count
   assign trial     = {rem_ff, dvd_ff[zpr_pkg::MORTON_BITS-1]};
   assign ge        = trial >= {1'b0, n_eff};
   assign trial_sub = trial - {1'b0, n_eff};
   assign rem_in    = ge ? trial_sub[zpr_pkg::DEST_BITS-1:0] : trial[zpr_pkg::DEST_BITS-1:0];

   assign per_inc_in = {1'b0, quot_ff} + zpr_pkg::DEN_BITS'(1);
   assign lo_prod    = rem_ff * per_inc_in;

   assign csr_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         origin_z_ff   <= '0;
         scale_x_ff    <= zpr_pkg::SCALE_RESET;
         scale_y_ff    <= zpr_pkg::SCALE_RESET;
         scale_z_ff    <= zpr_pkg::SCALE_RESET;
         grid_last_ff  <= zpr_pkg::GRID_RESET;
         dest_count_ff <= zpr_pkg::DEST_RESET;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               dvd_ff   <= mx;
               rem_ff   <= '0;
               quot_ff  <= '0;
               step_ff  <= zpr_pkg::STEP_BITS'(zpr_pkg::MORTON_BITS - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               dvd_ff  <= {dvd_ff[zpr_pkg::MORTON_BITS-2:0], 1'b0};
               rem_ff  <= rem_in;
               quot_ff <= {quot_ff[zpr_pkg::MORTON_BITS-2:0], ge};
               step_ff <= step_ff - zpr_pkg::STEP_BITS'(1);
               if (step_ff == '0) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               per_inc_ff <= per_inc_in;
               lo_ff      <= lo_prod[zpr_pkg::MORTON_BITS-1:0];
               state_ff   <= ST_IDLE;
            end
            ST_IDLE: begin
               // Recompute the split after every write
               if (csr_valid) begin
                  state_ff <= ST_LOAD;
               end
            end
         endcase
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               zpr_pkg::CSR_ORIGIN_X:   origin_x_ff   <= csr_data;
               zpr_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= csr_data;
               zpr_pkg::CSR_ORIGIN_Z:   origin_z_ff   <= csr_data;
               zpr_pkg::CSR_SCALE_X:    scale_x_ff    <= csr_data;
               zpr_pkg::CSR_SCALE_Y:    scale_y_ff    <= csr_data;
               zpr_pkg::CSR_SCALE_Z:    scale_z_ff    <= csr_data;
               zpr_pkg::CSR_GRID_LAST:  grid_last_ff  <= csr_data[zpr_pkg::GRID_BITS-1:0];
               zpr_pkg::CSR_DEST_COUNT: dest_count_ff <= csr_data[zpr_pkg::DEST_BITS-1:0];
            endcase
         end
      end
   end

   always_comb begin
      cfg          = '0;
      cfg.origin_x = origin_x_ff;
      cfg.origin_y = origin_y_ff;
      cfg.origin_z = origin_z_ff;
      cfg.scale_x  = scale_x_ff;
      cfg.scale_y  = scale_y_ff;
      cfg.scale_z  = scale_z_ff;
      cfg.last_x   = last_x;
      cfg.last_y   = last_y;
      cfg.last_z   = last_z;
      cfg.n        = n_eff;
      cfg.n_last   = n_eff - zpr_pkg::DEST_BITS'(1);
      cfg.per      = quot_ff;
      cfg.per_inc  = per_inc_ff;
      cfg.off      = rem_ff;
      cfg.lo       = lo_ff;
   end

endmodule

`default_nettype wire

[hdl/zpr_front.sv]
// ----------------------------------------------------------------------------
// zpr_front: cell mapping, Morton interleave and range classification
// Three stages: offset from origin, scale multiply, clamp and classify.
// ----------------------------------------------------------------------------
`default_nettype none

module zpr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  zpr_pkg::req_type     in_item,
   input  zpr_pkg::cfg_type     cfg,
   output logic                 push,
   output zpr_pkg::entry_type   push_entry
);

   localparam int CB = zpr_pkg::COORD_BITS;
   localparam int AB = zpr_pkg::AXIS_BITS;
   localparam int MB = zpr_pkg::MORTON_BITS;

   logic [2:0]                 vld_ff;
   logic [CB-1:0]              d_ff   [3];
   logic [2:0]                 pos_ff;
   logic [CB-1:0]              hi_ff  [3];
   logic [zpr_pkg::TAG_BITS-1:0] tag0_ff, tag1_ff;
   zpr_pkg::entry_type         entry_ff;

   logic signed [CB-1:0] pos_w [3];
   logic signed [CB-1:0] org_w [3];
   logic [CB-1:0]        scl_w [3];
   logic [AB-1:0]        last_w[3];
   logic [CB:0]          diff  [3];
   logic [2*CB-1:0]      prod  [3];
   logic [AB-1:0]        cell_idx [3];
   logic [MB-1:0]        m;
   logic [MB-1:0]        m_sub;
   zpr_pkg::entry_type   entry_in;

   assign pos_w[0]  = in_item.pos_x;
   assign pos_w[1]  = in_item.pos_y;
   assign pos_w[2]  = in_item.pos_z;
   assign org_w[0]  = cfg.origin_x;
   assign org_w[1]  = cfg.origin_y;
   assign org_w[2]  = cfg.origin_z;
   assign scl_w[0]  = cfg.scale_x;
   assign scl_w[1]  = cfg.scale_y;
   assign scl_w[2]  = cfg.scale_z;
   assign last_w[0] = cfg.last_x;
   assign last_w[1] = cfg.last_y;
   assign last_w[2] = cfg.last_z;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]     = {pos_w[a][CB-1], pos_w[a]} - {org_w[a][CB-1], org_w[a]};
         prod[a]     = d_ff[a] * scl_w[a];
         cell_idx[a] = (hi_ff[a] > CB'(last_w[a])) ? last_w[a] : hi_ff[a][AB-1:0];
      end
   end

   // Codes below lo fall in the wider ranges; the rest count from lo
   assign m     = zpr_pkg::interleave(cell_idx[0], cell_idx[1], cell_idx[2]);
   assign m_sub = m - cfg.lo;

   always_comb begin
      entry_in        = '0;
      entry_in.tag    = tag1_ff;
      entry_in.morton = m;
      if (m < cfg.lo) begin
         entry_in.num = m;
         entry_in.den = cfg.per_inc;
      end else begin
         entry_in.num       = m_sub;
         entry_in.den       = {1'b0, cfg.per};
         entry_in.base      = cfg.off;
         entry_in.last_dest = (cfg.per == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         d_ff[a]   <= diff[a][CB-1:0];
         pos_ff[a] <= !diff[a][CB] && (diff[a] != '0);
         hi_ff[a]  <= pos_ff[a] ? prod[a][2*CB-1:CB] : '0;
      end
      tag0_ff  <= in_item.particle_index;
      tag1_ff  <= tag0_ff;
      entry_ff <= entry_in;
   end

   assign push       = vld_ff[2];
   assign push_entry = entry_ff;

endmodule

`default_nettype wire

[hdl/zpr_queue.sv]
// ----------------------------------------------------------------------------
// zpr_queue: short queue between front end and divider
// Small register queue; the top level keeps it from overflowing.
// ----------------------------------------------------------------------------
`default_nettype none

module zpr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  zpr_pkg::entry_type   push_entry,
   input  logic                 pop,
   output logic                 head_valid,
   output zpr_pkg::entry_type   head_entry
);

   zpr_pkg::entry_type                mem [zpr_pkg::QUEUE_DEPTH];
   logic [zpr_pkg::QPTR_BITS-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [zpr_pkg::OCC_BITS-1:0]      count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + zpr_pkg::QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + zpr_pkg::QPTR_BITS'(1);
         end
         count_ff <= count_ff + zpr_pkg::OCC_BITS'(push) - zpr_pkg::OCC_BITS'(pop);
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

endmodule

`default_nettype wire

[hdl/zpr_back.sv]
// ----------------------------------------------------------------------------
// zpr_back: pipelined range divider and result register
// One quotient bit per stage, then offset, clamp and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module zpr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  zpr_pkg::entry_type   head_entry,
   output logic                 pop,
   input  zpr_pkg::cfg_type     cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output zpr_pkg::rsp_type     rsp_payload
);

   localparam int MB = zpr_pkg::MORTON_BITS;
   localparam int DB = zpr_pkg::DEN_BITS;
   localparam int SB = zpr_pkg::SUM_BITS;

   typedef struct packed {
      logic [MB-1:0]                rem;
      logic [MB-1:0]                num;
      logic [DB-1:0]                den;
      logic [zpr_pkg::DEST_BITS-1:0] base;
      logic                         last_dest;
      logic [zpr_pkg::TAG_BITS-1:0] tag;
      logic [MB-1:0]                morton;
   } stage_type;

   stage_type         st_ff [MB+1];
   stage_type         st_in [MB+1];
   logic [MB:0]       vld_ff;
   logic              rsp_valid_ff;
   zpr_pkg::rsp_type  rsp_ff, rsp_in;
   logic              adv;
   logic [SB-1:0]     sum;

   // Freeze the whole divider while a finished result is held
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && head_valid;

   always_comb begin
      st_in[0]           = '0;
      st_in[0].num       = head_entry.num;
      st_in[0].den       = head_entry.den;
      st_in[0].base      = head_entry.base;
      st_in[0].last_dest = head_entry.last_dest;
      st_in[0].tag       = head_entry.tag;
      st_in[0].morton    = head_entry.morton;
   end

   for (genvar k = 0; k < MB; k++) begin : g_step
      logic [DB-1:0] trial, trial_sub;
      logic          ge;
      assign trial     = {st_ff[k].rem, st_ff[k].num[MB-1]};
      assign ge        = trial >= st_ff[k].den;
      assign trial_sub = trial - st_ff[k].den;
      always_comb begin
         st_in[k+1]     = st_ff[k];
         st_in[k+1].rem = ge ? trial_sub[MB-1:0] : trial[MB-1:0];
         st_in[k+1].num = {st_ff[k].num[MB-2:0], ge};
      end
   end

   assign sum = SB'(st_ff[MB].base) + SB'(st_ff[MB].num);

   always_comb begin
      rsp_in              = '0;
      rsp_in.particle_tag = st_ff[MB].tag;
      rsp_in.morton_code  = st_ff[MB].morton;
      if (st_ff[MB].last_dest || (sum >= SB'(cfg.n))) begin
         rsp_in.destination = cfg.n_last;
      end else begin
         rsp_in.destination = sum[zpr_pkg::DEST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[MB-1:0], pop};
         rsp_valid_ff <= vld_ff[MB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= MB; k++) begin
            st_ff[k] <= st_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

[hdl/zorder_particle_router_core.sv]
// ----------------------------------------------------------------------------
// zorder_particle_router_core: Z-order particle partition router
// Maps each particle position to a Morton code and destination partition.
// ----------------------------------------------------------------------------
// Request channel (req_*): one particle position and index per transaction,
// taken when req_valid is high and req_stall low. Response channel (rsp_*):
// one result per request, in order, with tag, destination and Morton code.
// Configuration (csr_*): register index and data, written when csr_valid and
// csr_ready are both high; write only while no requests are in flight.
// Throughput is one transaction per cycle while req_stall is low. Each request
// passes three front stages, one queue slot, a 30-stage bit-per-stage divider
// and the result register.
// After reset and after every register write the range split is recomputed
// by a bit-serial divider, during which req_stall and csr_ready hold the
// block. Reset restores all register defaults.
// A stalled response holds the divider pipeline; the front end runs on into
// the eight-entry queue; req_stall rises once front end and queue hold eight.
// ----------------------------------------------------------------------------
`default_nettype none

module zorder_particle_router_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  zpr_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output zpr_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [zpr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [zpr_pkg::COORD_BITS-1:0]   csr_data
);

   zpr_pkg::cfg_type             cfg;
   zpr_pkg::entry_type           push_entry, head_entry;
   logic                         push, pop, head_valid, accept;
   logic [zpr_pkg::OCC_BITS-1:0] occ_ff, occ_in;

   // Count transactions in the front end and queue together
   assign req_stall = !csr_ready || (occ_ff >= zpr_pkg::OCC_BITS'(zpr_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign occ_in    = occ_ff + zpr_pkg::OCC_BITS'(accept) - zpr_pkg::OCC_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   zpr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   zpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_item    (req_payload),
      .cfg        (cfg),
      .push       (push),
      .push_entry (push_entry)
   );

   zpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   zpr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

[hdl/zpr_checker.sv]
// ----------------------------------------------------------------------------
// zpr_checker: port-level checks for the particle router
// Reset behaviour, recompute hold after writes, and response hold on stall.
// ----------------------------------------------------------------------------
`default_nettype none

module zpr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input zpr_pkg::rsp_type rsp_payload,
   input logic             csr_valid,
   input logic             csr_ready
);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_reset_busy: assert property (@(posedge clock) reset |=> (req_stall && !csr_ready))
      else $error("block not busy recomputing after reset");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (req_stall && !csr_ready))
      else $error("requests or writes taken during recompute");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

endmodule

bind zorder_particle_router_core zpr_checker u_zpr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);

`default_nettype wire
